[design/rlp_pkg.sv]
// Shared types and constants of the reflectance line position engine.
// Holds the item structs, the command, mode and register codes, and the sizing
// constants. It has no dependencies.
package rlp_pkg;

  localparam int MaxSensors      = 8;
  localparam int SampleBits      = 12;
  localparam int FullScale       = 1000;
  localparam int MinWindow       = 10;
  localparam int LostPerSensor   = 50;
  localparam int FilterOldWeight = 3;

  localparam int SensorBits = 3;
  localparam int CountBits  = 4;
  localparam int CalBits    = 10;
  localparam int PosBits    = 13;
  localparam int WsumBits   = 26;
  localparam int VsumBits   = 13;
  localparam int DivSteps   = WsumBits;
  localparam int DivCntBits = 5;
  localparam int CfgIdxBits = 4;
  localparam int CfgDataBits = 10;

  // Input item kinds. Any other code is handled as a calibrate item.
  localparam logic [1:0] KindCalibrate = 2'd0;
  localparam logic [1:0] KindMeasure   = 2'd1;
  localparam logic [1:0] KindReset     = 2'd2;

  // Read modes.
  localparam logic [1:0] ModeDark    = 2'd0;
  localparam logic [1:0] ModeLit     = 2'd1;
  localparam logic [1:0] ModeAmbient = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] RegSensorCount   = 4'd0;
  localparam logic [CfgIdxBits-1:0] RegReadMode      = 4'd1;
  localparam logic [CfgIdxBits-1:0] RegLineColour    = 4'd2;
  localparam logic [CfgIdxBits-1:0] RegLineThreshold = 4'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [SensorBits-1:0] sensor;
    logic [SampleBits-1:0] reading;
    logic [SampleBits-1:0] ambient;
    logic                  frame_end;
  } in_item_t;

  typedef struct packed {
    logic [SensorBits-1:0] sensor_out;
    logic [CalBits-1:0]    calibrated;
    logic [PosBits-1:0]    position;
    logic                  position_valid;
    logic                  line_lost;
    logic                  last;
  } out_item_t;

endpackage

[design/reflectance_line_position.sv]
// Top level of the reflectance line position engine: configuration registers,
// calibration windows, sample filter, sequencer and one shared serial divider.
// Depends on rlp_pkg.

// Calibrate and reset items are taken without leaving the idle state. A
// measure item on an active sensor is filtered, scaled, mapped onto its
// calibrated window by the serial restoring divider, weighted, accumulated
// and checked in that order; on another sensor it is only checked. On the
// item that closes a frame, the weighted average goes through the same
// divider once more unless the line is lost. The input stalls while
// an item is in progress; a finished result sits in the output register and
// the next item is taken while it waits.
module reflectance_line_position (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rlp_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rlp_pkg::out_item_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rlp_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [rlp_pkg::CfgDataBits-1:0]    cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FILT = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_WGT  = 9'b000010000,
    S_ACC  = 9'b000100000,
    S_FEND = 9'b001000000,
    S_POS  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  localparam int SB = rlp_pkg::SampleBits;

  // Configuration registers.
  logic [rlp_pkg::CountBits-1:0] sensor_count_q;
  logic [1:0]                    read_mode_q;
  logic                          line_colour_q;
  logic [rlp_pkg::CalBits-1:0]   line_threshold_q;

  // Per-sensor state.
  logic [SB-1:0] filter_q   [rlp_pkg::MaxSensors];
  logic [SB-1:0] lit_min_q  [rlp_pkg::MaxSensors];
  logic [SB-1:0] lit_max_q  [rlp_pkg::MaxSensors];
  logic [SB-1:0] dark_min_q [rlp_pkg::MaxSensors];
  logic [SB-1:0] dark_max_q [rlp_pkg::MaxSensors];

  state_e                        state_q;
  logic                          seeded_q;
  logic [rlp_pkg::WsumBits-1:0]  wsum_q;
  logic [rlp_pkg::VsumBits-1:0]  vsum_q;
  logic [rlp_pkg::PosBits-1:0]   prev_pos_q;
  logic                          out_valid_q;
  rlp_pkg::out_item_t            out_data_q;

  // Item context.
  logic [rlp_pkg::SensorBits-1:0] sensor_q;
  logic [SB-1:0]                  lit_q;
  logic                           fend_q;
  logic                           in_range_q;
  logic                           dark_sel_q;
  logic [rlp_pkg::PosBits-1:0]    sensor_pos_q;
  logic [SB-1:0]                  v_q;
  logic [SB-1:0]                  lo_q;
  logic [SB-1:0]                  hi_q;
  logic [rlp_pkg::CalBits-1:0]    cal_q;
  logic [rlp_pkg::CalBits-1:0]    wadd_q;
  logic [rlp_pkg::WsumBits-1:0]   prod_q;
  logic [rlp_pkg::PosBits-1:0]    pos_q;
  logic                           lost_q;

  // Shared divider.
  logic [rlp_pkg::WsumBits-1:0]   div_dvd_q;
  logic [rlp_pkg::VsumBits-1:0]   div_dsr_q;
  logic [rlp_pkg::VsumBits-1:0]   div_rem_q;
  logic [rlp_pkg::DivCntBits-1:0] div_cnt_q;
  logic                           div_pos_q;

  logic                          in_fire;
  logic [rlp_pkg::CountBits-1:0] n_act;
  logic [1:0]                    mode;
  logic                          in_range;
  logic [SB-1:0]                 lit_in;
  logic [SB+1:0]                 filt_sum;
  logic [SB-1:0]                 v_new;
  logic [SB-1:0]                 diff;
  logic [rlp_pkg::VsumBits:0]    div_trial;
  logic                          div_ge;
  logic [rlp_pkg::VsumBits-1:0]  div_rem_next;
  logic                          window_ok;
  logic [rlp_pkg::CalBits-1:0]   cal_sel;
  logic [rlp_pkg::CalBits-1:0]   w_sel;
  logic                          w_pass;
  logic [rlp_pkg::PosBits-1:0]   lost_limit;
  logic [rlp_pkg::PosBits-1:0]   half_pos;
  logic [rlp_pkg::PosBits-1:0]   edge_pos;
  logic                          is_lost;
  logic                          out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign n_act = ((sensor_count_q == '0) ||
                  (sensor_count_q > rlp_pkg::CountBits'(rlp_pkg::MaxSensors)))
                 ? rlp_pkg::CountBits'(rlp_pkg::MaxSensors) : sensor_count_q;
  // The spare mode code behaves as emitters off.
  assign mode = ((read_mode_q == rlp_pkg::ModeLit) || (read_mode_q == rlp_pkg::ModeAmbient))
                ? read_mode_q : rlp_pkg::ModeDark;
  assign in_range = ({1'b0, in_data_i.sensor} < n_act);
  assign lit_in = (mode != rlp_pkg::ModeAmbient) ? in_data_i.reading :
                  (in_data_i.reading > in_data_i.ambient) ?
                  (in_data_i.reading - in_data_i.ambient) : '0;

  // 3/4 low-pass filter; the first measured frame seeds it unfiltered.
  assign filt_sum = (SB+2)'(filter_q[sensor_q]) * (SB+2)'(rlp_pkg::FilterOldWeight)
                    + (SB+2)'(lit_q);
  assign v_new    = seeded_q ? filt_sum[SB+1:2] : lit_q;
  assign diff     = (v_q > lo_q) ? (v_q - lo_q) : '0;

  // One restoring step of the divider per cycle.
  assign div_trial    = {div_rem_q, div_dvd_q[rlp_pkg::WsumBits-1]};
  assign div_ge       = (div_trial >= {1'b0, div_dsr_q});
  assign div_rem_next = div_ge ? rlp_pkg::VsumBits'(div_trial - {1'b0, div_dsr_q})
                               : div_trial[rlp_pkg::VsumBits-1:0];

  assign window_ok = ({1'b0, hi_q} >= ((SB+1)'(lo_q) + (SB+1)'(rlp_pkg::MinWindow)));

  always_comb begin
    if (!window_ok || (v_q <= lo_q)) begin
      cal_sel = '0;
    end else if (v_q >= hi_q) begin
      cal_sel = rlp_pkg::CalBits'(rlp_pkg::FullScale);
    end else begin
      cal_sel = div_dvd_q[rlp_pkg::CalBits-1:0];
    end
  end

  assign w_sel  = line_colour_q ? (rlp_pkg::CalBits'(rlp_pkg::FullScale) - cal_sel) : cal_sel;
  assign w_pass = (w_sel > line_threshold_q);

  assign lost_limit = rlp_pkg::PosBits'(n_act) * rlp_pkg::PosBits'(rlp_pkg::LostPerSensor);
  assign half_pos   = rlp_pkg::PosBits'(n_act >> 1) * rlp_pkg::PosBits'(rlp_pkg::FullScale);
  assign edge_pos   = rlp_pkg::PosBits'(n_act - 4'd1) * rlp_pkg::PosBits'(rlp_pkg::FullScale);
  assign is_lost    = (vsum_q < lost_limit);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_count_q   <= rlp_pkg::CountBits'(rlp_pkg::MaxSensors);
      read_mode_q      <= rlp_pkg::ModeLit;
      line_colour_q    <= 1'b0;
      line_threshold_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rlp_pkg::RegSensorCount:   sensor_count_q   <= cfg_data_i[rlp_pkg::CountBits-1:0];
        rlp_pkg::RegReadMode:      read_mode_q      <= cfg_data_i[1:0];
        rlp_pkg::RegLineColour:    line_colour_q    <= cfg_data_i[0];
        rlp_pkg::RegLineThreshold: line_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Calibration windows, updated in the cycle of the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rlp_pkg::MaxSensors; i++) begin
        lit_min_q[i]  <= '1;
        lit_max_q[i]  <= '0;
        dark_min_q[i] <= '1;
        dark_max_q[i] <= '0;
      end
    end else if (in_fire) begin
      case (in_data_i.kind)
        rlp_pkg::KindReset: begin
          for (int i = 0; i < rlp_pkg::MaxSensors; i++) begin
            lit_min_q[i]  <= '1;
            lit_max_q[i]  <= '0;
            dark_min_q[i] <= '1;
            dark_max_q[i] <= '0;
          end
        end
        rlp_pkg::KindMeasure: ;
        default: begin
          if (in_range) begin
            if (mode == rlp_pkg::ModeDark) begin
              if (in_data_i.reading < dark_min_q[in_data_i.sensor])
                dark_min_q[in_data_i.sensor] <= in_data_i.reading;
              if (in_data_i.reading > dark_max_q[in_data_i.sensor])
                dark_max_q[in_data_i.sensor] <= in_data_i.reading;
            end else begin
              if (lit_in < lit_min_q[in_data_i.sensor])
                lit_min_q[in_data_i.sensor] <= lit_in;
              if (lit_in > lit_max_q[in_data_i.sensor])
                lit_max_q[in_data_i.sensor] <= lit_in;
            end
            // With ambient subtraction the dark set learns the ambient sample.
            if (mode == rlp_pkg::ModeAmbient) begin
              if (in_data_i.ambient < dark_min_q[in_data_i.sensor])
                dark_min_q[in_data_i.sensor] <= in_data_i.ambient;
              if (in_data_i.ambient > dark_max_q[in_data_i.sensor])
                dark_max_q[in_data_i.sensor] <= in_data_i.ambient;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rlp_pkg::MaxSensors; i++) begin
        filter_q[i] <= '0;
      end
    end else if ((state_q == S_FILT) && in_range_q) begin
      filter_q[sensor_q] <= v_new;
    end
  end

  // Sequencer and frame accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seeded_q    <= 1'b0;
      wsum_q      <= '0;
      vsum_q      <= '0;
      prev_pos_q  <= rlp_pkg::PosBits'((rlp_pkg::MaxSensors - 1) * rlp_pkg::FullScale / 2);
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && (in_data_i.kind == rlp_pkg::KindMeasure)) begin
            state_q <= S_FILT;
          end
        end
        S_FILT: begin
          state_q <= in_range_q ? S_MUL : S_FEND;
        end
        S_MUL: begin
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + rlp_pkg::DivCntBits'(1);
          if (div_cnt_q == rlp_pkg::DivCntBits'(rlp_pkg::DivSteps - 1)) begin
            state_q <= div_pos_q ? S_POS : S_WGT;
          end
        end
        S_WGT: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          wsum_q  <= wsum_q + prod_q;
          vsum_q  <= vsum_q + rlp_pkg::VsumBits'(wadd_q);
          state_q <= S_FEND;
        end
        S_FEND: begin
          if (!fend_q) begin
            state_q <= S_DONE;
          end else if (is_lost) begin
            wsum_q   <= '0;
            vsum_q   <= '0;
            seeded_q <= 1'b1;
            state_q  <= S_DONE;
          end else begin
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end
        end
        S_POS: begin
          prev_pos_q <= div_dvd_q[rlp_pkg::PosBits-1:0];
          wsum_q     <= '0;
          vsum_q     <= '0;
          seeded_q   <= 1'b1;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          sensor_q     <= in_data_i.sensor;
          lit_q        <= lit_in;
          fend_q       <= in_data_i.frame_end;
          in_range_q   <= in_range;
          dark_sel_q   <= (mode == rlp_pkg::ModeDark);
          sensor_pos_q <= rlp_pkg::PosBits'(in_data_i.sensor) *
                          rlp_pkg::PosBits'(rlp_pkg::FullScale);
        end
      end
      S_FILT: begin
        v_q   <= v_new;
        lo_q  <= dark_sel_q ? dark_min_q[sensor_q] : lit_min_q[sensor_q];
        hi_q  <= dark_sel_q ? dark_max_q[sensor_q] : lit_max_q[sensor_q];
        cal_q <= '0;
      end
      S_MUL: begin
        div_dvd_q <= rlp_pkg::WsumBits'(diff) * rlp_pkg::WsumBits'(rlp_pkg::FullScale);
        div_dsr_q <= rlp_pkg::VsumBits'(hi_q - lo_q);
        div_rem_q <= '0;
        div_pos_q <= 1'b0;
      end
      S_DIV: begin
        div_rem_q <= div_rem_next;
        div_dvd_q <= {div_dvd_q[rlp_pkg::WsumBits-2:0], div_ge};
      end
      S_WGT: begin
        cal_q <= cal_sel;
        if (w_pass) begin
          wadd_q <= w_sel;
          prod_q <= rlp_pkg::WsumBits'(w_sel) * rlp_pkg::WsumBits'(sensor_pos_q);
        end else begin
          wadd_q <= '0;
          prod_q <= '0;
        end
      end
      S_FEND: begin
        pos_q  <= '0;
        lost_q <= 1'b0;
        if (fend_q && is_lost) begin
          lost_q <= 1'b1;
          pos_q  <= (prev_pos_q < half_pos) ? '0 : edge_pos;
        end else if (fend_q) begin
          div_dvd_q <= wsum_q;
          div_dsr_q <= vsum_q;
          div_rem_q <= '0;
          div_pos_q <= 1'b1;
        end
      end
      S_POS: begin
        pos_q <= div_dvd_q[rlp_pkg::PosBits-1:0];
      end
      S_DONE: begin
        if (out_free) begin
          out_data_q.sensor_out     <= sensor_q;
          out_data_q.calibrated     <= cal_q;
          out_data_q.position       <= pos_q;
          out_data_q.position_valid <= fend_q;
          out_data_q.line_lost      <= lost_q;
          out_data_q.last           <= fend_q;
        end
      end
      default: ;
    endcase
  end

  // A result only appears after the sequencer has finished an item.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the final step");

  a_lost_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.line_lost) |-> (out_data_o.position_valid && out_data_o.last))
    else $error("lost line flagged on a result that does not close a frame");

  a_cal_in_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (cal_q <= rlp_pkg::CalBits'(rlp_pkg::FullScale)))
    else $error("calibrated value above full scale");

  a_div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_cnt_q < rlp_pkg::DivCntBits'(rlp_pkg::DivSteps)))
    else $error("divider step count overran");

endmodule

[dv/reflectance_line_position_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the reflectance line position engine: mirrors configuration
// writes, predicts one result per measure transfer and checks output transfers
// in order. Depends on rlp_pkg.
module reflectance_line_position_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  rlp_pkg::in_item_t               in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  rlp_pkg::out_item_t              out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [rlp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [rlp_pkg::CfgDataBits-1:0] cfg_data_i,
  output int                              error_count_o,
  output int                              pending_o
);
  import rlp_pkg::*;

  typedef logic [SampleBits-1:0] sample_t;

  // Register copies.
  logic [CountBits-1:0] count_reg;
  logic [1:0]           mode_reg;
  logic                 colour_reg;
  logic [CalBits-1:0]   threshold_reg;

  // Per-sensor filter and calibration windows.
  sample_t filtered [MaxSensors];
  bit      seeded;
  sample_t lit_lo  [MaxSensors];
  sample_t lit_hi  [MaxSensors];
  sample_t dark_lo [MaxSensors];
  sample_t dark_hi [MaxSensors];

  longint unsigned weight_acc;
  longint unsigned value_acc;
  int unsigned     last_position;

  out_item_t expected_results [$];
  out_item_t want;
  int        errors;

  task automatic clear_windows();
    foreach (lit_lo[i]) begin
      lit_lo[i]  = '1;
      lit_hi[i]  = '0;
      dark_lo[i] = '1;
      dark_hi[i] = '0;
    end
  endtask

  task automatic widen(input bit dark_set, input int unsigned idx, input int unsigned v);
    if (dark_set) begin
      if (v < dark_lo[idx]) dark_lo[idx] = sample_t'(v);
      if (v > dark_hi[idx]) dark_hi[idx] = sample_t'(v);
    end else begin
      if (v < lit_lo[idx]) lit_lo[idx] = sample_t'(v);
      if (v > lit_hi[idx]) lit_hi[idx] = sample_t'(v);
    end
  endtask

  // Updates the calibration and filter state for one accepted item and queues
  // the result that a measure item produces.
  task automatic predict_reading(input in_item_t it);
    int unsigned n, lit, v, lo, hi, cal, w, sensor;
    logic [1:0]  mode;
    bit          in_range;
    out_item_t   res;
    n = (count_reg == 0 || count_reg > MaxSensors) ? MaxSensors : count_reg;
    // The spare mode code behaves as emitters off.
    mode = (mode_reg == ModeLit || mode_reg == ModeAmbient) ? mode_reg : ModeDark;
    sensor = it.sensor;
    in_range = sensor < n;
    if (mode == ModeAmbient) lit = (it.reading > it.ambient) ? it.reading - it.ambient : 0;
    else lit = it.reading;

    if (it.kind == KindReset) begin
      clear_windows();
      return;
    end
    if (it.kind != KindMeasure) begin
      if (in_range) begin
        if (mode == ModeDark) widen(1'b1, sensor, it.reading);
        else widen(1'b0, sensor, lit);
        if (mode == ModeAmbient) widen(1'b1, sensor, it.ambient);
      end
      return;
    end

    cal = 0;
    if (in_range) begin
      if (seeded) begin
        filtered[sensor] = sample_t'((filtered[sensor] * FilterOldWeight + lit) >> 2);
      end else begin
        filtered[sensor] = sample_t'(lit);
      end
      v  = filtered[sensor];
      lo = (mode == ModeDark) ? dark_lo[sensor] : lit_lo[sensor];
      hi = (mode == ModeDark) ? dark_hi[sensor] : lit_hi[sensor];
      if (hi >= lo + MinWindow) begin
        if (v <= lo) cal = 0;
        else if (v >= hi) cal = FullScale;
        else cal = (v - lo) * FullScale / (hi - lo);
      end
      w = colour_reg ? FullScale - cal : cal;
      if (w > threshold_reg) begin
        weight_acc += w * sensor * FullScale;
        value_acc  += w;
      end
    end

    res = '0;
    res.sensor_out = it.sensor;
    res.calibrated = CalBits'(cal);
    if (it.frame_end) begin
      res.position_valid = 1'b1;
      res.last = 1'b1;
      if (value_acc < n * LostPerSensor) begin
        // Line lost: report the edge on the side where it was last seen.
        res.line_lost = 1'b1;
        res.position = (last_position < (n / 2) * FullScale) ? '0 : PosBits'((n - 1) * FullScale);
      end else begin
        res.position = PosBits'(weight_acc / value_acc);
        last_position = res.position;
      end
      weight_acc = 0;
      value_acc = 0;
      seeded = 1'b1;
    end
    expected_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_reg = CountBits'(MaxSensors);
      mode_reg = ModeLit;
      colour_reg = 1'b0;
      threshold_reg = '0;
      foreach (filtered[i]) filtered[i] = '0;
      seeded = 1'b0;
      clear_windows();
      weight_acc = 0;
      value_acc = 0;
      last_position = (MaxSensors - 1) * FullScale / 2;
      expected_results.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegSensorCount:   count_reg = cfg_data_i[CountBits-1:0];
          RegReadMode:      mode_reg = cfg_data_i[1:0];
          RegLineColour:    colour_reg = cfg_data_i[0];
          RegLineThreshold: threshold_reg = cfg_data_i[CalBits-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          $error("result for sensor %0d with no measure transfer outstanding",
                 out_data_i.sensor_out);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.sensor_out !== want.sensor_out) begin
            errors++;
            $error("sensor_out: expected %0d, got %0d", want.sensor_out, out_data_i.sensor_out);
          end
          if (out_data_i.calibrated !== want.calibrated) begin
            errors++;
            $error("calibrated: expected %0d, got %0d", want.calibrated, out_data_i.calibrated);
          end
          if (out_data_i.position !== want.position) begin
            errors++;
            $error("position: expected %0d, got %0d", want.position, out_data_i.position);
          end
          if (out_data_i.position_valid !== want.position_valid) begin
            errors++;
            $error("position_valid: expected %0d, got %0d", want.position_valid,
                   out_data_i.position_valid);
          end
          if (out_data_i.line_lost !== want.line_lost) begin
            errors++;
            $error("line_lost: expected %0d, got %0d", want.line_lost, out_data_i.line_lost);
          end
          if (out_data_i.last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, out_data_i.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_reading(in_data_i);
      error_count_o <= errors;
      pending_o <= expected_results.size();
    end
  end

endmodule

[dv/reflectance_line_position_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the reflectance line position engine: clock, reset,
// configuration and sample stimulus, output back-pressure and the verdict.
// Depends on rlp_pkg, the engine and reflectance_line_position_checker.
module reflectance_line_position_tb;
  import rlp_pkg::*;

  localparam int ItemTarget  = 1100;
  localparam int StallLimit  = 3000;
  // A frame-closing measure item is the slowest kind of item.
  localparam int DrainCycles = 64;
  localparam int HoldCycles  = 300;

  // Codes outside the package: the spare kind is taken as calibrate, the
  // spare mode as emitters off.
  localparam logic [1:0] KindSpare = 2'd3;
  localparam logic [1:0] ModeSpare = 2'd3;

  typedef enum int {FrameLine, FrameBlank, FrameBright} frame_style_e;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index;
  logic [CfgDataBits-1:0] cfg_data;
  int                     error_count;
  int                     pending;

  bit          quiet;
  bit          long_hold;
  int unsigned active_n;
  int unsigned item_count;

  reflectance_line_position dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  reflectance_line_position_checker scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t make_item(input logic [1:0] kind, input int unsigned sensor,
                                         input int unsigned reading, input int unsigned ambient,
                                         input bit frame_end);
    in_item_t it;
    it.kind      = kind;
    it.sensor    = SensorBits'(sensor);
    it.reading   = SampleBits'(reading);
    it.ambient   = SampleBits'(ambient);
    it.frame_end = frame_end;
    return it;
  endfunction

  task automatic offer_sample(input in_item_t it);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    // Calibrate items on sensors outside the active set are ignored.
    if (it.kind == KindMeasure || it.kind == KindReset || it.sensor < active_n) item_count++;
  endtask

  // Stops offering and waits until every result is back and the engine has
  // finished any item that produces none.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One well-formed measure frame over the active sensors.
  task automatic scan_frame(input int unsigned n, input int unsigned centre,
                            input frame_style_e style);
    int unsigned span, reading;
    for (int s = 0; s < n; s++) begin
      span = (centre > s * FullScale) ? centre - s * FullScale : s * FullScale - centre;
      case (style)
        FrameBlank:  reading = $urandom_range(0, 300);
        FrameBright: reading = $urandom_range(3600, 4095);
        default: begin
          reading = (span < 1500) ? 3800 - 2 * span + $urandom_range(0, 200)
                                  : $urandom_range(100, 700);
        end
      endcase
      offer_sample(make_item(KindMeasure, s, reading, $urandom_range(0, 700), s == n - 1));
    end
  endtask

  initial begin : stimulus
    int unsigned       seed_frame [MaxSensors];
    logic [CfgIdxBits-1:0] reg_order [4];
    logic [1:0]        mode_order [4];
    int unsigned       settings [4];
    int unsigned       count_val, frames, pick;
    seed_frame = '{2048, 102, 4095, 0, 1, 2, 3, 4095};
    reg_order  = '{RegSensorCount, RegReadMode, RegLineColour, RegLineThreshold};
    mode_order = '{ModeDark, ModeLit, ModeAmbient, ModeSpare};
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= RegSensorCount;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    quiet = 1'b0;
    long_hold = 1'b0;
    active_n = MaxSensors;
    item_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings.
    offer_sample(make_item(KindReset, 7, 4095, 4095, 1'b1));
    offer_sample(make_item(KindCalibrate, 0, 0, 0, 1'b0));
    offer_sample(make_item(KindCalibrate, 0, 4095, 4095, 1'b0));
    // Sensor 1 gets a window narrower than the minimum, so it maps to zero.
    offer_sample(make_item(KindCalibrate, 1, 100, 0, 1'b0));
    offer_sample(make_item(KindCalibrate, 1, 105, 0, 1'b0));
    // A frame end on a calibrate item closes nothing.
    offer_sample(make_item(KindSpare, 2, 4095, 0, 1'b1));
    offer_sample(make_item(KindSpare, 2, 0, 4095, 1'b1));
    // The first measure frame seeds the filter with the raw samples.
    for (int s = 0; s < MaxSensors; s++) begin
      offer_sample(make_item(KindMeasure, s, seed_frame[s], 4095 - seed_frame[s],
                             s == MaxSensors - 1));
    end
    scan_frame(MaxSensors, 0, FrameBlank);

    for (int p = 0; item_count < ItemTarget; p++) begin
      wait_idle();
      quiet = (p % 3 == 1);
      case (p % 6)
        0:       count_val = MaxSensors;
        1:       count_val = 1;
        2:       count_val = 0;
        3:       count_val = 15;
        default: count_val = $urandom_range(2, MaxSensors);
      endcase
      settings[0] = count_val;
      settings[1] = mode_order[p % 4];
      settings[2] = (p / 4) % 2;
      case (p % 5)
        0:       settings[3] = 0;
        1:       settings[3] = FullScale;
        2:       settings[3] = 1023;
        default: settings[3] = $urandom_range(0, 300);
      endcase
      for (int r = 0; r < 4; r++) begin
        cfg_valid <= 1'b1;
        cfg_index <= reg_order[r];
        cfg_data  <= CfgDataBits'(settings[r]);
        do @(posedge clk); while (!cfg_ready);
      end
      cfg_valid <= 1'b0;
      active_n = (count_val == 0 || count_val > MaxSensors) ? MaxSensors : count_val;

      if ($urandom_range(0, 1)) begin
        offer_sample(make_item(KindReset, $urandom_range(0, 7), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), 1'($urandom_range(0, 1))));
      end
      // Calibration sweeps: a dark pass, a bright pass, then anything.
      for (int k = 0; k < 3; k++) begin
        for (int s = 0; s < active_n; s++) begin
          case (k)
            0: offer_sample(make_item(KindCalibrate, s, $urandom_range(0, 800),
                                      $urandom_range(0, 400), 1'b0));
            1: offer_sample(make_item(KindCalibrate, s, $urandom_range(2800, 4095),
                                      $urandom_range(0, 400), 1'b0));
            default: offer_sample(make_item(KindCalibrate, s, $urandom_range(0, 4095),
                                            $urandom_range(0, 4095),
                                            1'($urandom_range(0, 1))));
          endcase
        end
      end
      if (p == 2) wait_idle();
      if (p == 3) long_hold = 1'b1;
      frames = $urandom_range(3, 6);
      for (int f = 0; f < frames; f++) begin
        pick = $urandom_range(0, 19);
        scan_frame(active_n, $urandom_range(0, (active_n - 1) * FullScale),
                   (pick < 12) ? FrameLine : (pick < 17) ? FrameBlank : FrameBright);
      end
      // Unstructured items: any kind, any sensor, broken frames.
      for (int i = 0; i < 8; i++) begin
        offer_sample(make_item(2'($urandom_range(0, 3)), $urandom_range(0, 7),
                               $urandom_range(0, 4095), $urandom_range(0, 4095),
                               1'($urandom_range(0, 1))));
      end
    end

    wait_idle();
    if (error_count == 0 && pending == 0) begin
      $display("reflectance_line_position_tb: done, clean");
    end else begin
      $display("reflectance_line_position_tb: done, errors");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned wait_cycles;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        // Hold off long enough for the engine to fill and stall its input.
        wait_cycles = HoldCycles;
        long_hold = 1'b0;
      end else begin
        wait_cycles = quiet ? 0 : $urandom_range(0, 9);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("reflectance_line_position_tb: done, errors");
    $finish;
  end

endmodule
